[rtl/core/btpc_pkg.sv]
// shared types, constants and helpers for the barometer compensation unit
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int RawW = 20;
  localparam int DivStages = 64;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  typedef enum logic [1:0] {
    CFG_TEMP   = 2'd0,
    CFG_PRESSA = 2'd1,
    CFG_PRESSB = 2'd2,
    CFG_PRESSC = 2'd3
  } cfg_idx_t;

  // front to back queue entry
  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] x2;
    logic [63:0] x1;
    logic [RawW-1:0] adc_p;
  } fe_item_t;

  // divider lane payload
  typedef struct packed {
    logic        vld;
    logic        fault;
    logic        neg;
    logic [31:0] temp;
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
  } div_lane_t;

  typedef struct packed {
    logic        vld;
    logic        fault;
    logic [31:0] temp;
    logic [63:0] p;
  } bk_item_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

[rtl/core/btpc_front.sv]
// front pipeline: fine temperature, temperature and pressure divisor terms
`timescale 1ns / 1ps
module btpc_front
  import btpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [RawW-1:0] in_p,
  input  logic [RawW-1:0] in_t,
  input  logic [47:0]     cal_t,
  input  logic [63:0]     cal_a,
  input  logic [63:0]     cal_b,
  output logic            fe_vld,
  output fe_item_t        fe_item
);

  logic [6:0]  vld_r;
  // stage 1
  logic [31:0] a_r, d_r;
  logic [RawW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  // stage 2
  logic [31:0] m1_r, dd_r;
  // stage 3
  logic [31:0] v1_r, dds_r;
  // stage 4
  logic [31:0] v1b_r, m3_r;
  // stage 5
  logic [31:0] fine_r;
  // stage 6 (temp7_r is the stage 7 copy of temp)
  logic [31:0] temp_r, temp7_r;
  logic [63:0] x_r;
  // stage 7 products
  logic [63:0] xx_r, xp5_r, xp2_r;
  // stage 8
  logic [63:0] xxp6_r, xxp3_r, xp5b_r, xp2b_r;
  logic [31:0] temp8_r;
  logic [RawW-1:0] p8_r;
  // stage 9
  logic [63:0] x2_r, x1a_r;
  logic [31:0] temp9_r;
  logic [RawW-1:0] p9_r;
  // stage 10
  logic [63:0] x1p_r;
  logic [31:0] temp10_r;
  logic [RawW-1:0] p10_r;
  logic [63:0] x2b_r;
  logic [2:0]  vld2_r;

  logic [31:0] t1, t2, t3;
  assign t1 = {16'd0, cal_t[15:0]};
  assign t2 = {{16{cal_t[31]}}, cal_t[31:16]};
  assign t3 = {{16{cal_t[47]}}, cal_t[47:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld2_r <= '0;
    end else begin
      vld_r  <= {vld_r[5:0], in_vld};
      vld2_r <= {vld2_r[1:0], vld_r[6]};
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= {15'd0, in_t[RawW-1:3]} - (t1 << 1);
    d_r  <= {16'd0, in_t[RawW-1:4]} - t1;
    p1_r <= in_p;
    m1_r <= a_r * t2;
    dd_r <= d_r * d_r;
    p2_r <= p1_r;
    v1_r  <= $signed(m1_r) >>> 11;
    dds_r <= $signed(dd_r) >>> 12;
    p3_r  <= p2_r;
    v1b_r <= v1_r;
    m3_r  <= dds_r * t3;
    p4_r  <= p3_r;
    fine_r <= v1b_r + 32'($signed(m3_r) >>> 14);
    p5_r   <= p4_r;
    temp_r <= 32'($signed(fine_r * 32'd5 + 32'd128) >>> 8);
    x_r    <= {{32{fine_r[31]}}, fine_r} - 64'd128000;
    p6_r   <= p5_r;
    temp7_r <= temp_r;
    // x fits in 33 signed bits
    xx_r    <= 64'($signed(x_r[32:0]) * $signed(x_r[32:0]));
    xp5_r   <= x_r * sx16(cal_b[15:0]);
    xp2_r   <= x_r * sx16(cal_a[31:16]);
    p7_r    <= p6_r;
    xxp6_r  <= xx_r * sx16(cal_b[31:16]);
    xxp3_r  <= xx_r * sx16(cal_a[47:32]);
    xp5b_r  <= xp5_r;
    xp2b_r  <= xp2_r;
    temp8_r <= temp7_r;
    p8_r    <= p7_r;
    x2_r    <= xxp6_r + (xp5b_r << 17) + (sx16(cal_a[63:48]) << 35);
    x1a_r   <= 64'($signed(xxp3_r) >>> 8) + (xp2b_r << 12) + (64'd1 << 47);
    temp9_r <= temp8_r;
    p9_r    <= p8_r;
    x1p_r   <= x1a_r * {48'd0, cal_a[15:0]};
    x2b_r   <= x2_r;
    temp10_r <= temp9_r;
    p10_r   <= p9_r;
  end

  assign fe_vld        = vld2_r[2];
  assign fe_item.temp  = temp10_r;
  assign fe_item.x2    = x2b_r;
  assign fe_item.x1    = 64'($signed(x1p_r) >>> 33);
  assign fe_item.adc_p = p10_r;

endmodule

[rtl/core/btpc_queue.sv]
// short fifo between the front and back pipelines
`timescale 1ns / 1ps
module btpc_queue
  import btpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  fe_item_t wr_data,
  output logic     rd_vld,
  output fe_item_t rd_data
);

  fe_item_t        mem_r [QDepth];
  logic [QAw-1:0]  wp_r, rp_r;
  logic [QAw:0]    cnt_r;

  // back end never stalls, so pop whenever not empty
  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_vld) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(wr_en) - (QAw+1)'(rd_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

[rtl/core/btpc_back.sv]
// back pipeline: pipelined signed divide and final pressure terms
`timescale 1ns / 1ps
module btpc_back
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  fe_item_t    item,
  input  logic [63:0] cal_b,
  input  logic [15:0] cal_c,
  output logic        out_vld,
  output logic [31:0] out_temp,
  output logic [31:0] out_press,
  output logic        out_fault
);

  div_lane_t   s0_r;
  logic [63:0] num;
  logic        pre_vld_r, pre_fault_r;
  logic [31:0] pre_temp_r;
  logic [63:0] pre_x1_r, pre_mul_r;
  div_lane_t   lane_r [DivStages+1];
  bk_item_t    q_r, e1_r, e2_r, e3_r;
  logic [63:0] h_r, p9h_r, y2_r, y1_r, ll_r;
  logic [31:0] lh_r, hl_r;
  logic [63:0] p3_r;
  logic        o_vld_r, o_fault_r;
  logic [31:0] o_temp_r, o_press_r;
  logic [63:0] base;

  assign base = (64'd1048576 - {44'd0, item.adc_p}) << 31;
  assign num  = pre_mul_r * 64'd3125;

  always_ff @(posedge clk) begin
    if (!rst_n) pre_vld_r <= 1'b0;
    else pre_vld_r <= in_vld;
    pre_fault_r <= item.x1 == '0;
    pre_temp_r  <= item.temp;
    pre_x1_r    <= item.x1;
    pre_mul_r   <= base - item.x2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else s0_r.vld <= pre_vld_r;
    s0_r.fault <= pre_fault_r;
    s0_r.temp  <= pre_temp_r;
    s0_r.neg   <= num[63] ^ pre_x1_r[63];
    s0_r.num   <= num[63] ? 64'(0) - num : num;
    s0_r.den   <= pre_x1_r[63] ? 64'(0) - pre_x1_r : pre_x1_r;
    s0_r.rem   <= '0;
  end

  assign lane_r[0] = s0_r;

  // one quotient bit per stage
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    div_lane_t   nx;
    logic [64:0] tr;
    always_comb begin
      nx = lane_r[g];
      tr = {lane_r[g].rem, lane_r[g].num[63]} - {1'b0, lane_r[g].den};
      nx.num = {lane_r[g].num[62:0], 1'b0};
      if (!tr[64]) begin
        nx.rem    = tr[63:0];
        nx.num[0] = 1'b1;
      end else begin
        nx.rem = {lane_r[g].rem[62:0], lane_r[g].num[63]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) lane_r[g+1].vld <= 1'b0;
      else lane_r[g+1].vld <= nx.vld;
      lane_r[g+1].fault <= nx.fault;
      lane_r[g+1].neg   <= nx.neg;
      lane_r[g+1].temp  <= nx.temp;
      lane_r[g+1].rem   <= nx.rem;
      lane_r[g+1].num   <= nx.num;
      lane_r[g+1].den   <= nx.den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld  <= 1'b0;
      e1_r.vld <= 1'b0;
      e2_r.vld <= 1'b0;
      e3_r.vld <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      q_r.vld  <= lane_r[DivStages].vld;
      e1_r.vld <= q_r.vld;
      e2_r.vld <= e1_r.vld;
      e3_r.vld <= e2_r.vld;
      o_vld_r  <= e3_r.vld;
    end
    q_r.fault <= lane_r[DivStages].fault;
    q_r.temp  <= lane_r[DivStages].temp;
    q_r.p     <= lane_r[DivStages].neg ? 64'(0) - lane_r[DivStages].num
                                        : lane_r[DivStages].num;
    e1_r.fault <= q_r.fault;
    e1_r.temp  <= q_r.temp;
    e1_r.p     <= q_r.p;
    h_r   <= 64'($signed(q_r.p) >>> 13);
    p9h_r <= sx16(cal_c) * 64'($signed(q_r.p) >>> 13);
    y2_r  <= sx16(cal_b[63:48]) * q_r.p;
    e2_r.fault <= e1_r.fault;
    e2_r.temp  <= e1_r.temp;
    e2_r.p     <= e1_r.p;
    // low 64 bits of p9h * h from 32 bit partial products
    ll_r  <= {32'd0, p9h_r[31:0]} * {32'd0, h_r[31:0]};
    lh_r  <= p9h_r[31:0] * h_r[63:32];
    hl_r  <= p9h_r[63:32] * h_r[31:0];
    p3_r  <= 64'($signed(y2_r) >>> 19);
    e3_r.fault <= e2_r.fault;
    e3_r.temp  <= e2_r.temp;
    e3_r.p     <= e2_r.p + 64'($signed(p3_r) >>> 0);
    y1_r  <= 64'($signed(ll_r + {lh_r + hl_r, 32'd0}) >>> 25);
    o_fault_r <= e3_r.fault;
    o_temp_r  <= e3_r.temp;
    o_press_r <= e3_r.fault ? 32'd0
               : 32'(64'($signed(e3_r.p + y1_r) >>> 8) + (sx16(cal_b[47:32]) << 4));
  end

  assign out_vld   = o_vld_r;
  assign out_temp  = o_temp_r;
  assign out_press = o_press_r;
  assign out_fault = o_fault_r;

endmodule

[rtl/core/barometer_temp_pressure_compensation_unit.sv]
// top level of the barometer temperature and pressure compensation unit
//
//  channel | handshake            | payload
//  in      | start & !busy        | in_raw_pressure, in_raw_temperature
//  out     | out_valid (1 cycle)  | out_temperature_centi, out_pressure_fx, out_divide_fault
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// one transaction per cycle; the path to out_valid runs mostly through the
// 64 stage restoring divider in the back pipeline
// busy stays low: the front, queue and back never stall, nor can the receiver
// synchronous active low reset clears valid flags and calibration words
`timescale 1ns / 1ps
module barometer_temp_pressure_compensation_unit
  import btpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [RawW-1:0] in_raw_pressure,
  input  logic [RawW-1:0] in_raw_temperature,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  output logic            out_valid,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]     out_pressure_fx,
  output logic            out_divide_fault
);

  logic [47:0] cal_t_r;
  logic [63:0] cal_a_r, cal_b_r;
  logic [15:0] cal_c_r;
  logic        fe_vld, q_vld;
  fe_item_t    fe_item, q_item;
  logic [31:0] temp;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r <= '0;
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP:   cal_t_r <= cfg_data[47:0];
        CFG_PRESSA: cal_a_r <= cfg_data;
        CFG_PRESSB: cal_b_r <= cfg_data;
        CFG_PRESSC: cal_c_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  btpc_front u_front (
    .clk, .rst_n,
    .in_vld(start), .in_p(in_raw_pressure), .in_t(in_raw_temperature),
    .cal_t(cal_t_r), .cal_a(cal_a_r), .cal_b(cal_b_r),
    .fe_vld, .fe_item
  );

  btpc_queue u_queue (
    .clk, .rst_n, .wr_en(fe_vld), .wr_data(fe_item),
    .rd_vld(q_vld), .rd_data(q_item)
  );

  btpc_back u_back (
    .clk, .rst_n, .in_vld(q_vld), .item(q_item),
    .cal_b(cal_b_r), .cal_c(cal_c_r),
    .out_vld(out_valid), .out_temp(temp),
    .out_press(out_pressure_fx), .out_fault(out_divide_fault)
  );

  assign out_temperature_centi = $signed(temp);

endmodule
